>>> hw/rtl/bst_pkg.sv
// Shared types, codes and constants of the BCD stopwatch timer.
package bst_pkg;

    // Request kind codes.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_TICK  = 2'd0;
    localparam kind_t KIND_WRITE = 2'd1;
    localparam kind_t KIND_READ  = 2'd2;

    // Register select codes.
    typedef logic [2:0] sel_t;
    localparam sel_t SEL_FLAGS = 3'd0;
    localparam sel_t SEL_MASK  = 3'd1;
    localparam sel_t SEL_LOW   = 3'd2;
    localparam sel_t SEL_HIGH  = 3'd3;
    localparam sel_t SEL_CTRL  = 3'd4;

    typedef logic [3:0] nibble_t;
    typedef logic [3:0] digit_t;
    typedef logic [1:0] slice_t;
    typedef logic [1:0] flags_t;

    // Last digit value and the length of a long slice.
    localparam digit_t DigitLast = 4'd9;
    localparam slice_t LongSlice = 2'd3;

    // Flag bit positions.
    localparam int FLAG_10HZ = 0;
    localparam int FLAG_1HZ  = 1;

endpackage

>>> hw/rtl/bst_channels.sv
// Request and result channel interfaces of the BCD stopwatch timer.
interface bst_cmd_if import bst_pkg::*; ();
    logic    valid;
    logic    ready;
    kind_t   kind;
    sel_t    reg_select;
    nibble_t write_data;

    modport source (output valid, kind, reg_select, write_data, input ready);
    modport sink   (input valid, kind, reg_select, write_data, output ready);
endinterface

interface bst_rsp_if import bst_pkg::*; ();
    logic    valid;
    logic    ready;
    nibble_t read_data;
    logic    irq_request;

    modport source (output valid, read_data, irq_request, input ready);
    modport sink   (input valid, read_data, irq_request, output ready);
endinterface

>>> hw/rtl/bcd_stopwatch_timer.sv
// BCD stopwatch timer: takes one request (a 256 Hz half-period tick, a register
// write or a register read) per clock and returns exactly one result per request,
// in the next cycle, from an output register. A new request is taken in every cycle
// while the result register is empty or is being drained in the same cycle, so the
// sustained rate is one request per clock; only a stalled result holds off input.
// The stopwatch state updates in the cycle a request is accepted.
module bcd_stopwatch_timer import bst_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    bst_cmd_if.sink      cmd,
    bst_rsp_if.source    rsp
);

    // Stopwatch state.
    logic    source_reg, source_next;
    logic    gated_reg, gated_next;
    logic    running_reg, running_next;
    slice_t  slice_reg, slice_next;
    digit_t  hund_reg, hund_next;
    digit_t  tenths_reg, tenths_next;
    flags_t  flags_reg, flags_next;
    flags_t  mask_reg, mask_next;

    // Result register.
    logic    rsp_valid_reg;
    nibble_t read_data_reg, read_data_next;
    logic    irq_reg, irq_next;

    // Values before the counter advance.
    slice_t  slice_base;
    digit_t  hund_base;
    digit_t  tenths_base;
    flags_t  flags_base;
    logic    do_advance;

    // Counter advance terms.
    slice_t  slice_inc;
    slice_t  slice_len;
    digit_t  hund_step;
    digit_t  tenths_step;

    logic    accept;

    assign cmd.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    // Decode the request and apply its direct effects.
    always_comb
    begin
        source_next    = source_reg;
        gated_next     = gated_reg;
        running_next   = running_reg;
        mask_next      = mask_reg;
        slice_base     = slice_reg;
        hund_base      = hund_reg;
        tenths_base    = tenths_reg;
        flags_base     = flags_reg;
        do_advance     = 1'b0;
        read_data_next = '0;
        if (accept)
        begin
            case (cmd.kind)
                KIND_TICK:
                begin
                    source_next = !source_reg;
                    gated_next  = !source_reg || !running_reg;
                    do_advance  = source_reg && running_reg;
                end
                KIND_WRITE:
                begin
                    if (cmd.reg_select == SEL_MASK)
                    begin
                        mask_next = cmd.write_data[1:0];
                    end
                    else if (cmd.reg_select == SEL_CTRL)
                    begin
                        running_next = cmd.write_data[0];
                        if (cmd.write_data[1])
                        begin
                            slice_base  = '0;
                            hund_base   = '0;
                            tenths_base = '0;
                        end
                        // Starting while gated and the source is low clocks the counter at once.
                        if (cmd.write_data[0] && gated_reg && !source_reg)
                        begin
                            gated_next = 1'b0;
                            do_advance = 1'b1;
                        end
                    end
                end
                KIND_READ:
                begin
                    case (cmd.reg_select)
                        SEL_FLAGS:
                        begin
                            read_data_next = {2'b00, flags_reg};
                            flags_base     = '0;
                        end
                        SEL_MASK: read_data_next = {2'b00, mask_reg};
                        SEL_LOW:  read_data_next = hund_reg;
                        SEL_HIGH: read_data_next = tenths_reg;
                        SEL_CTRL: read_data_next = {3'b000, running_reg};
                        default:  read_data_next = '0;
                    endcase
                end
                default:
                begin
                    read_data_next = '0;
                end
            endcase
        end
    end

    // Slice counter and BCD digit advance.
    always_comb
    begin
        slice_inc   = slice_base + 2'd1;
        slice_len   = LongSlice - {1'b0, hund_base[0]};
        if (hund_base == 4'd1 && !tenths_base[1])
        begin
            slice_len = LongSlice;
        end
        hund_step   = (hund_base >= DigitLast) ? 4'd0 : hund_base + 4'd1;
        tenths_step = (tenths_base >= DigitLast) ? 4'd0 : tenths_base + 4'd1;

        slice_next  = slice_base;
        hund_next   = hund_base;
        tenths_next = tenths_base;
        flags_next  = flags_base;
        if (do_advance)
        begin
            slice_next = slice_inc;
            if (slice_inc == slice_len)
            begin
                slice_next = '0;
                hund_next  = hund_step;
                if (hund_step == 4'd0)
                begin
                    flags_next[FLAG_10HZ] = 1'b1;
                    tenths_next           = tenths_step;
                    if (tenths_step == 4'd0)
                    begin
                        flags_next[FLAG_1HZ] = 1'b1;
                    end
                end
            end
        end
        irq_next = |(flags_next & mask_next);
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg    <= 1'b0;
            gated_reg     <= 1'b0;
            running_reg   <= 1'b0;
            slice_reg     <= '0;
            hund_reg      <= '0;
            tenths_reg    <= '0;
            flags_reg     <= '0;
            mask_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            source_reg  <= source_next;
            gated_reg   <= gated_next;
            running_reg <= running_next;
            slice_reg   <= slice_next;
            hund_reg    <= hund_next;
            tenths_reg  <= tenths_next;
            flags_reg   <= flags_next;
            mask_reg    <= mask_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload loads with each accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg <= read_data_next;
            irq_reg       <= irq_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_data   = read_data_reg;
    assign rsp.irq_request = irq_reg;

`ifndef NO_ASSERTIONS
    // The digits always hold valid BCD.
    assert property (@(posedge clk) disable iff (!rst_n)
        hund_reg <= DigitLast && tenths_reg <= DigitLast)
        else $error("stopwatch digit left BCD range");

    // A slice never reaches the long slice length.
    assert property (@(posedge clk) disable iff (!rst_n) slice_reg != LongSlice)
        else $error("slice counter overran");

    // No request is taken while a stalled result occupies the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |-> !cmd.ready)
        else $error("request accepted over a stalled result");

    // A flags read leaves the flags clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.kind == KIND_READ && cmd.reg_select == SEL_FLAGS)
        |=> flags_reg == '0)
        else $error("flags not cleared by read");
`endif

endmodule
